// ===== src/cfpp_pkg.sv =====
// Package for the framed packet parser: field widths, codes, CRC byte step.
// No dependencies.
`default_nettype none
package cfpp_pkg;
    localparam int CMD_ENTRIES_DEF = 4;
    localparam logic [7:0]  START_BYTE  = 8'hE8;
    localparam logic [7:0]  VERSION_ONE = 8'h01;
    localparam logic [15:0] END_WORD    = 16'h0A0D;
    localparam logic [7:0]  WILD_ADDR   = 8'h00;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [16:0] GAP_MAX     = 17'h1FFFF;

    localparam logic [2:0] CFG_LOCAL_ADDR = 3'd0;
    localparam logic [2:0] CFG_LOCAL_DYN  = 3'd1;
    localparam logic [2:0] CFG_MAX_PAY    = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd3;
    localparam logic [2:0] CFG_SEED       = 3'd4;
    localparam logic [2:0] CFG_CMD_TABLE  = 3'd5;
    localparam logic [2:0] CFG_CMD_VALID  = 3'd6;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    localparam logic [2:0] DR_VERSION = 3'd0;
    localparam logic [2:0] DR_ADDRESS = 3'd1;
    localparam logic [2:0] DR_COMMAND = 3'd2;
    localparam logic [2:0] DR_LENGTH  = 3'd3;
    localparam logic [2:0] DR_CRC     = 3'd4;
    localparam logic [2:0] DR_END     = 3'd5;
    localparam logic [2:0] DR_TIMEOUT = 3'd6;

    typedef enum logic [9:0] {
        PH_IDLE = 10'b0000000001,
        PH_VER  = 10'b0000000010,
        PH_SRC  = 10'b0000000100,
        PH_DST  = 10'b0000001000,
        PH_CMD  = 10'b0000010000,
        PH_ACK  = 10'b0000100000,
        PH_LEN  = 10'b0001000000,
        PH_DATA = 10'b0010000000,
        PH_CRC  = 10'b0100000000,
        PH_END  = 10'b1000000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  drop_reason;
        logic [7:0]  frame_src;
        logic [7:0]  frame_src_dyn;
        logic [7:0]  frame_dst;
        logic [7:0]  frame_dst_dyn;
        logic [7:0]  command_set;
        logic [7:0]  command_word;
        logic [7:0]  ack_flag;
        logic [15:0] payload_len;
        logic        routed;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/cfpp_parser.sv =====
// Frame parse step: registered input byte feeds phase logic, result register out.
// Depends on cfpp_pkg.
`default_nettype none
module cfpp_parser
    import cfpp_pkg::*;
#(
    parameter int CMD_ENTRIES = CMD_ENTRIES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_go,
    input  wire logic        in_cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic [7:0]  local_addr,
    input  wire logic [7:0]  local_dyn_addr,
    input  wire logic [15:0] max_payload,
    input  wire logic [15:0] timeout_ticks,
    input  wire logic [15:0] crc_seed,
    input  wire logic [63:0] cmd_table,
    input  wire logic [3:0]  cmd_table_valid,
    output logic             res_go,
    output result_t          res
);
    phase_t      phase_reg, phase_next;
    logic        second_reg, second_next, route_reg, route_next;
    logic [15:0] crc_reg, crc_next, len_reg, len_next, left_reg, left_next;
    logic [7:0]  src_reg, src_next, srcd_reg, srcd_next, dst_reg, dst_next;
    logic [7:0]  dstd_reg, dstd_next, cset_reg, cset_next, cword_reg, cword_next;
    logic [7:0]  ack_reg, ack_next, crcl_reg, crcl_next, endl_reg, endl_next;
    logic [16:0] gap_reg, gap_next;
    logic        emit;
    logic        tmo_hit;
    logic [1:0]  ekind;
    logic [7:0]  epay;
    logic [2:0]  ereason;
    logic        known;
    logic [15:0] key, crc_in, len_full;

    always_comb
    begin
        key = {cset_reg, in_byte};
        known = 1'b0;
        for (int i = 0; i < CMD_ENTRIES; i++)
        begin
            if (cmd_table_valid[i] && cmd_table[16*i +: 16] == key)
                known = 1'b1;
        end
    end

    assign crc_in   = crc_byte(crc_reg, in_byte);
    assign len_full = {in_byte, len_reg[7:0]};

    always_comb
    begin
        phase_next = phase_reg; second_next = second_reg; route_next = route_reg;
        crc_next = crc_reg; len_next = len_reg; left_next = left_reg;
        src_next = src_reg; srcd_next = srcd_reg; dst_next = dst_reg;
        dstd_next = dstd_reg; cset_next = cset_reg; cword_next = cword_reg;
        ack_next = ack_reg; crcl_next = crcl_reg; endl_next = endl_reg;
        gap_next = gap_reg;
        emit = 1'b0; tmo_hit = 1'b0;
        ekind = KIND_DROP; epay = 8'h00; ereason = DR_VERSION;
        if (in_go)
        begin
            if (in_cmd)
            begin
                if (gap_reg != GAP_MAX)
                    gap_next = gap_reg + 17'd1;
            end
            else
            begin
                gap_next = '0;
                if (phase_reg != PH_IDLE && gap_reg > {1'b0, timeout_ticks})
                begin
                    // timed out: drop, then treat byte as if waiting for start
                    emit = 1'b1; tmo_hit = 1'b1; ereason = DR_TIMEOUT;
                    phase_next = PH_IDLE; second_next = 1'b0;
                    if (in_byte == START_BYTE)
                    begin
                        crc_next = crc_byte(crc_seed, in_byte);
                        src_next = '0; srcd_next = '0; dst_next = '0; dstd_next = '0;
                        cset_next = '0; cword_next = '0; ack_next = '0;
                        len_next = '0; left_next = '0; route_next = 1'b0;
                        phase_next = PH_VER;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_IDLE:
                        begin
                            if (in_byte == START_BYTE)
                            begin
                                crc_next = crc_byte(crc_seed, in_byte);
                                src_next = '0; srcd_next = '0; dst_next = '0;
                                dstd_next = '0; cset_next = '0; cword_next = '0;
                                ack_next = '0; len_next = '0; left_next = '0;
                                route_next = 1'b0; second_next = 1'b0;
                                phase_next = PH_VER;
                            end
                        end
                        PH_VER:
                        begin
                            crc_next = crc_in; second_next = 1'b0;
                            if (in_byte != VERSION_ONE)
                            begin
                                emit = 1'b1; ereason = DR_VERSION; phase_next = PH_IDLE;
                            end
                            else
                                phase_next = PH_SRC;
                        end
                        PH_SRC:
                        begin
                            crc_next = crc_in;
                            if (!second_reg)
                            begin
                                src_next = in_byte; second_next = 1'b1;
                            end
                            else
                            begin
                                srcd_next = in_byte; second_next = 1'b0; phase_next = PH_DST;
                            end
                        end
                        PH_DST:
                        begin
                            crc_next = crc_in;
                            if (!second_reg)
                            begin
                                dst_next = in_byte;
                                route_next = !(in_byte == WILD_ADDR || in_byte == local_addr);
                                second_next = 1'b1;
                            end
                            else
                            begin
                                dstd_next = in_byte; second_next = 1'b0;
                                if (!(in_byte == WILD_ADDR || in_byte == local_dyn_addr)
                                    && !route_reg)
                                begin
                                    emit = 1'b1; ereason = DR_ADDRESS; phase_next = PH_IDLE;
                                end
                                else
                                    phase_next = PH_CMD;
                            end
                        end
                        PH_CMD:
                        begin
                            crc_next = crc_in;
                            if (!second_reg)
                            begin
                                cset_next = in_byte; second_next = 1'b1;
                            end
                            else
                            begin
                                cword_next = in_byte; second_next = 1'b0;
                                if (!route_reg && !known)
                                begin
                                    emit = 1'b1; ereason = DR_COMMAND; phase_next = PH_IDLE;
                                end
                                else
                                    phase_next = PH_ACK;
                            end
                        end
                        PH_ACK:
                        begin
                            crc_next = crc_in; ack_next = in_byte; len_next = '0;
                            second_next = 1'b0; phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            crc_next = crc_in;
                            if (!second_reg)
                            begin
                                len_next = {8'h00, in_byte}; second_next = 1'b1;
                            end
                            else
                            begin
                                len_next = len_full; second_next = 1'b0;
                                if (len_full > max_payload)
                                begin
                                    emit = 1'b1; ereason = DR_LENGTH; phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    left_next = len_full; phase_next = PH_DATA;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            if (left_reg != 16'd0)
                            begin
                                crc_next = crc_in; left_next = left_reg - 16'd1;
                                emit = 1'b1; ekind = KIND_PAYLOAD; epay = in_byte;
                            end
                            else
                            begin
                                crcl_next = in_byte; phase_next = PH_CRC;
                            end
                        end
                        PH_CRC:
                        begin
                            second_next = 1'b0;
                            if (crc_reg != {in_byte, crcl_reg})
                            begin
                                emit = 1'b1; ereason = DR_CRC; phase_next = PH_IDLE;
                            end
                            else
                                phase_next = PH_END;
                        end
                        PH_END:
                        begin
                            if (!second_reg)
                            begin
                                endl_next = in_byte; second_next = 1'b1;
                            end
                            else
                            begin
                                second_next = 1'b0; emit = 1'b1; phase_next = PH_IDLE;
                                if ({in_byte, endl_reg} != END_WORD)
                                    ereason = DR_END;
                                else
                                    ekind = KIND_ACCEPT;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE; second_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; second_reg <= 1'b0; route_reg <= 1'b0;
            crc_reg <= '0; len_reg <= '0; left_reg <= '0;
            src_reg <= '0; srcd_reg <= '0; dst_reg <= '0; dstd_reg <= '0;
            cset_reg <= '0; cword_reg <= '0; ack_reg <= '0;
            crcl_reg <= '0; endl_reg <= '0; gap_reg <= '0;
            res_go <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next; second_reg <= second_next; route_reg <= route_next;
            crc_reg <= crc_next; len_reg <= len_next; left_reg <= left_next;
            src_reg <= src_next; srcd_reg <= srcd_next; dst_reg <= dst_next;
            dstd_reg <= dstd_next; cset_reg <= cset_next; cword_reg <= cword_next;
            ack_reg <= ack_next; crcl_reg <= crcl_next; endl_reg <= endl_next;
            gap_reg <= gap_next;
            res_go <= emit;
        end
    end

    // header fields show values captured through this byte; a timeout drop
    // reports the frame it abandons, before any restart on this byte
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res.kind <= ekind; res.payload_byte <= epay;
            res.drop_reason <= (ekind == KIND_DROP) ? ereason : DR_VERSION;
            res.frame_src <= tmo_hit ? src_reg : src_next;
            res.frame_src_dyn <= tmo_hit ? srcd_reg : srcd_next;
            res.frame_dst <= tmo_hit ? dst_reg : dst_next;
            res.frame_dst_dyn <= tmo_hit ? dstd_reg : dstd_next;
            res.command_set <= tmo_hit ? cset_reg : cset_next;
            res.command_word <= tmo_hit ? cword_reg : cword_next;
            res.ack_flag <= tmo_hit ? ack_reg : ack_next;
            res.payload_len <= tmo_hit ? len_reg : len_next;
            res.routed <= tmo_hit ? route_reg : route_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/crc_framed_packet_parser_top.sv =====
// Top level: streaming ports, config registers, input register, output queue.
// Depends on cfpp_pkg and cfpp_parser.
//
// channel  dir  data
// s_axis   in   tdata[7:0] rx_byte, tuser cmd
// m_axis   out  tdata see port comment, tuser kind
// cfg      in   cfg_index, cfg_data
//
// One item per cycle while s_axis_tready is high; each item passes the input register,
// result register and output queue. A four-entry queue absorbs stalls; s_axis_tready
// drops once queued plus in-flight results reach four. Reset idles the parser.
`default_nettype none
module crc_framed_packet_parser_top
    import cfpp_pkg::*;
#(
    parameter int CMD_ENTRIES = CMD_ENTRIES_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // rx_byte
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // payload_byte, drop_reason, frame_src, frame_src_dyn, frame_dst, frame_dst_dyn,
    // command_set, command_word, ack_flag, payload_len, routed, 4 zero bits
    output logic [87:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,  // kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [7:0]  la_reg, lda_reg;
    logic [15:0] maxp_reg, tmo_reg, seed_reg;
    logic [63:0] tab_reg;
    logic [3:0]  tabv_reg;
    logic        in_go_reg, in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        res_go;
    result_t     res;
    result_t     q_reg [4];
    logic [2:0]  cnt_reg;
    logic [1:0]  rd_reg, wr_reg;
    logic        pop;
    logic [2:0]  pend;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg <= 8'd1; lda_reg <= 8'd0; maxp_reg <= 16'd256; tmo_reg <= 16'd1000;
            seed_reg <= 16'hFFFF; tab_reg <= '0; tabv_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR: la_reg   <= cfg_data[7:0];
                CFG_LOCAL_DYN:  lda_reg  <= cfg_data[7:0];
                CFG_MAX_PAY:    maxp_reg <= cfg_data[15:0];
                CFG_TIMEOUT:    tmo_reg  <= cfg_data[15:0];
                CFG_SEED:       seed_reg <= cfg_data[15:0];
                CFG_CMD_TABLE:  tab_reg  <= cfg_data;
                CFG_CMD_VALID:  tabv_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // accept while queue plus in-flight results leave room
    assign pend = cnt_reg + {2'b0, in_go_reg} + {2'b0, res_go};
    assign s_axis_tready = (pend < 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_go_reg <= 1'b0;
        else
            in_go_reg <= s_axis_tvalid && s_axis_tready;
    end

    always_ff @(posedge clk)
    begin
        in_cmd_reg  <= s_axis_tuser;
        in_byte_reg <= s_axis_tdata;
    end

    cfpp_parser #(.CMD_ENTRIES(CMD_ENTRIES)) u_parser (
        .clk(clk), .rst_n(rst_n), .in_go(in_go_reg), .in_cmd(in_cmd_reg),
        .in_byte(in_byte_reg), .local_addr(la_reg), .local_dyn_addr(lda_reg),
        .max_payload(maxp_reg), .timeout_ticks(tmo_reg), .crc_seed(seed_reg),
        .cmd_table(tab_reg), .cmd_table_valid(tabv_reg), .res_go(res_go), .res(res)
    );

    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; rd_reg <= '0; wr_reg <= '0;
        end
        else
        begin
            if (res_go) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, res_go} - {2'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_go)
            q_reg[wr_reg] <= res;
    end

    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tuser  = q_reg[rd_reg].kind;
    assign m_axis_tdata  = {4'd0, q_reg[rd_reg].routed, q_reg[rd_reg].payload_len,
                            q_reg[rd_reg].ack_flag, q_reg[rd_reg].command_word,
                            q_reg[rd_reg].command_set, q_reg[rd_reg].frame_dst_dyn,
                            q_reg[rd_reg].frame_dst, q_reg[rd_reg].frame_src_dyn,
                            q_reg[rd_reg].frame_src, q_reg[rd_reg].drop_reason,
                            q_reg[rd_reg].payload_byte};
endmodule
`default_nettype wire
